// File: sv/opls_pkg.sv
// ----------------------------------------------------------------------------
// opls_pkg
// Shared types, register indexes, reset values and the CORDIC arctangent
// table for the orbit phase-lock speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

package opls_pkg;

	localparam int VEHICLES_DEF     = 4;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;
	localparam int SEND_THRESHOLD   = 51;

	// stream payload widths, padded to whole bytes
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 40;

	// CORDIC working width: 33-bit difference, sign flip and gain growth
	localparam int CORDIC_W = 36;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CENTER_X      = 3'd0,
		REG_CENTER_Y      = 3'd1,
		REG_ANGLE_RATE    = 3'd2,
		REG_BASE_SPEED    = 3'd3,
		REG_ERROR_GAIN    = 3'd4,
		REG_SPEED_FLOOR   = 3'd5,
		REG_SPEED_CEILING = 3'd6,
		REG_SLOT_PHASES   = 3'd7
	} cfg_reg_t;

	localparam logic [15:0] BASE_SPEED_RST    = 16'd2048;
	localparam logic [15:0] ERROR_GAIN_RST    = 16'd11060;
	localparam logic [15:0] SPEED_FLOOR_RST   = 16'd1024;
	localparam logic [15:0] SPEED_CEILING_RST = 16'd3072;

	typedef struct packed {
		logic load;
		logic init;
		logic iter;
		logic calc_err;
		logic mul;
		logic clamp;
		logic commit;
	} opls_cmd_t;

	typedef struct packed {
		logic drop;
		logic iter_last;
		logic send;
		logic out_free;
	} opls_sts_t;

	// arctangent of 2^-i, 2^32 per turn
	function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
		logic [31:0] r;
		unique case (idx)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F;
			5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B;
			5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2;
			5'd23: r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/opls_ctrl.sv
// ----------------------------------------------------------------------------
// opls_ctrl
// Sequencer: accepts one item, walks the datapath through setup, the CORDIC
// iterations, error, gain multiply, clamp and send decision.
// ----------------------------------------------------------------------------
`default_nettype none

module opls_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire opls_pkg::opls_sts_t sts,
	output opls_pkg::opls_cmd_t     cmd
);
	import opls_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_INIT   = 7'b0000010,
		ST_ITER   = 7'b0000100,
		ST_ERR    = 7'b0001000,
		ST_MUL    = 7'b0010000,
		ST_CLAMP  = 7'b0100000,
		ST_DECIDE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		s_tready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				// stop requests and unknown vehicles finish at accept
				if (s_tvalid && !sts.drop) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_ITER;
			end
			ST_ITER: begin
				cmd.iter = 1'b1;
				if (sts.iter_last) begin
					state_d = ST_ERR;
				end
			end
			ST_ERR: begin
				cmd.calc_err = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = ST_DECIDE;
			end
			ST_DECIDE: begin
				// hold while a result to send finds the output still full
				if (!sts.send || sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/opls_dp.sv
// ----------------------------------------------------------------------------
// opls_dp
// Datapath: configuration registers, mission clock, iterative CORDIC atan2,
// phase error, gain and clamp, per-vehicle last sent speed, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module opls_dp #(
	parameter int VEHICLES     = opls_pkg::VEHICLES_DEF,
	parameter int CORDIC_STEPS = opls_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [opls_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [opls_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic [opls_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [opls_pkg::OUT_TDATA_W-1:0]       m_tdata,
	input  wire opls_pkg::opls_cmd_t               cmd,
	output opls_pkg::opls_sts_t                    sts
);
	import opls_pkg::*;

	localparam int VIDX_W = $clog2(VEHICLES);
	localparam int ITW    = $clog2(CORDIC_STEPS);
	localparam int CW     = CORDIC_W;

	// input fields
	logic [1:0]  in_vehicle;
	logic [31:0] in_pos_x, in_pos_y, in_now;
	assign in_vehicle = s_tdata[1:0];
	assign in_pos_x   = s_tdata[33:2];
	assign in_pos_y   = s_tdata[65:34];
	assign in_now     = s_tdata[97:66];

	// configuration
	logic [31:0] center_x_q, center_y_q, angle_rate_q;
	logic [15:0] base_speed_q, error_gain_q, speed_floor_q, speed_ceiling_q;
	logic [63:0] slot_phases_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q      <= '0;
			center_y_q      <= '0;
			angle_rate_q    <= '0;
			base_speed_q    <= BASE_SPEED_RST;
			error_gain_q    <= ERROR_GAIN_RST;
			speed_floor_q   <= SPEED_FLOOR_RST;
			speed_ceiling_q <= SPEED_CEILING_RST;
			slot_phases_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:      center_x_q      <= cfg_data[31:0];
				REG_CENTER_Y:      center_y_q      <= cfg_data[31:0];
				REG_ANGLE_RATE:    angle_rate_q    <= cfg_data[31:0];
				REG_BASE_SPEED:    base_speed_q    <= cfg_data[15:0];
				REG_ERROR_GAIN:    error_gain_q    <= cfg_data[15:0];
				REG_SPEED_FLOOR:   speed_floor_q   <= cfg_data[15:0];
				REG_SPEED_CEILING: speed_ceiling_q <= cfg_data[15:0];
				REG_SLOT_PHASES:   slot_phases_q   <= cfg_data;
			endcase
		end
	end

	// accept: mission clock and position offsets
	logic bad_index;
	assign bad_index = ({1'b0, in_vehicle} >= 3'(VEHICLES));
	assign sts.drop  = s_tuser || bad_index;

	logic        running_q;
	logic [31:0] start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			start_q   <= '0;
		end else if (cmd.load) begin
			if (s_tuser) begin
				running_q <= 1'b0;
			end else if (!bad_index && !running_q) begin
				running_q <= 1'b1;
				start_q   <= in_now;
			end
		end
	end

	logic signed [32:0] dx_q, dy_q;
	logic [31:0]        elapsed_q;
	logic [1:0]         v_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q      <= $signed({in_pos_x[31], in_pos_x}) - $signed({center_x_q[31], center_x_q});
			dy_q      <= $signed({in_pos_y[31], in_pos_y}) - $signed({center_y_q[31], center_y_q});
			elapsed_q <= running_q ? (in_now - start_q) : '0;
			v_q       <= in_vehicle;
		end
	end

	// setup: half-turn flip, target angle
	logic signed [CW-1:0] x_ext, y_ext;
	logic [63:0]          rate_prod;
	logic [15:0]          phase;
	assign x_ext     = {{(CW-33){dx_q[32]}}, dx_q};
	assign y_ext     = {{(CW-33){dy_q[32]}}, dy_q};
	assign rate_prod = {32'd0, angle_rate_q} * {32'd0, elapsed_q};
	assign phase     = slot_phases_q[{v_q, 4'b0000} +: 16];

	// CORDIC vectoring
	logic signed [CW-1:0] x_q, y_q, xs, ys;
	logic [31:0]          z_q;
	logic [ITW-1:0]       step_q;
	logic                 zero_q;
	logic [15:0]          target_q;
	logic [31:0]          atan_val;

	assign xs        = x_q >>> step_q;
	assign ys        = y_q >>> step_q;
	assign atan_val  = atan_lookup(5'(step_q));
	assign sts.iter_last = (step_q == ITW'(CORDIC_STEPS - 1));

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			if (dx_q[32]) begin
				x_q <= -x_ext;
				y_q <= -y_ext;
				z_q <= 32'h8000_0000;
			end else begin
				x_q <= x_ext;
				y_q <= y_ext;
				z_q <= '0;
			end
			zero_q   <= (dx_q == '0) && (dy_q == '0);
			step_q   <= '0;
			target_q <= phase + rate_prod[31:16];
		end else if (cmd.iter) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_val;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_val;
			end
			step_q <= step_q + 1'b1;
		end
	end

	// error, gain, clamp
	logic [31:0]        z_rnd;
	logic [15:0]        actual;
	logic signed [15:0] err_q;
	logic signed [16:0] gain_s;
	logic signed [32:0] gprod_q;
	logic signed [33:0] g_rnd;
	logic signed [17:0] g_adj;
	logic signed [18:0] raw, hi_lim, lo_lim, clip_hi;
	logic [15:0]        spd_q;

	assign z_rnd   = z_q + 32'h0000_8000;
	assign actual  = zero_q ? 16'd0 : z_rnd[31:16];
	assign gain_s  = $signed({1'b0, error_gain_q});
	assign g_rnd   = $signed({gprod_q[32], gprod_q}) + 34'sd32768;
	assign g_adj   = g_rnd[33:16];
	assign raw     = $signed({3'b000, base_speed_q}) + $signed({g_adj[17], g_adj});
	assign hi_lim  = $signed({3'b000, speed_ceiling_q});
	assign lo_lim  = $signed({3'b000, speed_floor_q});
	// ceiling first, then floor: floor wins when the two cross
	assign clip_hi = (raw > hi_lim) ? hi_lim : raw;

	always_ff @(posedge clk) begin
		if (cmd.calc_err) begin
			err_q <= $signed(target_q - actual);
		end
		if (cmd.mul) begin
			gprod_q <= gain_s * err_q;
		end
		if (cmd.clamp) begin
			spd_q <= (clip_hi < lo_lim) ? speed_floor_q : clip_hi[15:0];
		end
	end

	// send decision against the last speed sent to this vehicle
	logic [15:0]        last_q [VEHICLES];
	logic [VEHICLES-1:0] last_valid_q;
	logic [VIDX_W-1:0]  vi;
	logic signed [16:0] diff, adiff;
	logic [15:0]        last_spd;

	assign vi       = v_q[VIDX_W-1:0];
	assign last_spd = last_q[vi];
	assign diff     = $signed({1'b0, spd_q}) - $signed({1'b0, last_spd});
	assign adiff    = diff[16] ? -diff : diff;
	assign sts.send = !last_valid_q[vi] || (adiff > 17'(SEND_THRESHOLD));

	logic out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic do_send;

	assign do_send      = cmd.commit && sts.send;
	assign sts.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_valid_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (do_send) begin
				last_valid_q[vi] <= 1'b1;
				out_valid_q      <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_send) begin
			last_q[vi] <= spd_q;
			out_data_q <= {6'd0, spd_q, err_q, v_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

// File: sv/orbit_phase_lock_speed.sv
// ----------------------------------------------------------------------------
// orbit_phase_lock_speed
// Per-vehicle orbit phase-lock speed controller.
// Sequence: after an item is taken, the datapath runs setup, the CORDIC
// iterations, error, multiply, clamp and send decision before the result
// is registered at the output, later while the previous result still waits.
// Updates are taken one at a time, set by the single shared CORDIC stage
// iterating one step a cycle; stop items and unknown vehicle indexes end at accept.
// Reset: asynchronous, clears the clock, sent-speed valid bits and the
// output; configuration returns to its reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module orbit_phase_lock_speed #(
	parameter int VEHICLES     = opls_pkg::VEHICLES_DEF,
	parameter int CORDIC_STEPS = opls_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [opls_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [opls_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// vehicle_index[1:0], pos_x[33:2], pos_y[65:34], now_ms[97:66], zero pad
	input  wire logic [opls_pkg::IN_TDATA_W-1:0]   s_tdata,
	// req_type
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// out_vehicle[1:0], phase_error[17:2], speed_cmd[33:18], zero pad
	output logic [opls_pkg::OUT_TDATA_W-1:0]       m_tdata
);
	import opls_pkg::*;

	opls_cmd_t cmd;
	opls_sts_t sts;

	opls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	opls_dp #(
		.VEHICLES     (VEHICLES),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	// a stop item completes at accept
	a_stop_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> s_tready)
		else $error("stop item did not return to idle");

	// a new result appears only from a send decision
	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.commit))
		else $error("result raised without a commit");

	// the CORDIC runs exactly CORDIC_STEPS iterations
	a_iter_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init |-> ##(CORDIC_STEPS + 1) cmd.calc_err)
		else $error("wrong CORDIC iteration count");

	// an update is never taken while one is in flight
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.iter |-> !s_tready)
		else $error("input ready during CORDIC");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the orbit phase-lock speed controller. A short
// table of directed items runs first at the reset settings, then random
// vehicle updates and stop requests over several register settings. Every
// accepted item goes through a local bit-exact model of the CORDIC angle,
// phase error, clamp and send threshold, and each result item is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top;
	import opls_pkg::*;

	localparam int VEHICLES        = VEHICLES_DEF;
	localparam int CORDIC_STEPS    = CORDIC_STEPS_DEF;
	localparam int SEND_MARGIN     = 51;
	localparam int SETTLE_CYCLES   = CORDIC_STEPS + 6 + 10;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int DIRECTED_ROWS   = 17;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int DUE_DEPTH       = 64;

	// arctangent of 2^-i, 2^32 per turn
	localparam logic [31:0] ATAN_TAB [0:23] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef enum logic {
		REQ_UPDATE = 1'b0,
		REQ_STOP   = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		ROW_PREDICT     = 2'd0,
		ROW_EXPECT_ONE  = 2'd1,
		ROW_EXPECT_NONE = 2'd2
	} row_check_t;

	typedef struct packed {
		row_check_t  kind;
		req_kind_t   req;
		logic [1:0]  veh;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] now;
		logic [15:0] exp_err;
		logic [15:0] exp_speed;
	} step_row_t;

	typedef struct packed {
		logic [1:0]  veh;
		logic [15:0] err;
		logic [15:0] speed;
	} speed_cmd_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// local copy of the registers
	logic signed [31:0] ring_x, ring_y;
	logic [31:0]        sweep_rate;
	logic [15:0]        base_spd, gain, floor_spd, ceil_spd;
	logic [63:0]        slot_reg;

	// local copy of the block state
	bit          lock_running;
	logic [31:0] lock_t0;
	logic [15:0] sent_speed [0:3];
	bit          sent_ok [0:3];

	// predicted results in order, ring of write and read counts
	speed_cmd_t  due_buf [0:DUE_DEPTH-1];
	int unsigned due_wr;
	int unsigned due_rd;

	int unsigned fail_count;
	int unsigned items_sent;
	int unsigned stops_sent;
	int unsigned results_seen;
	int unsigned settings_used;
	int unsigned quiet_cycles;
	logic [31:0] now_t;
	bit          hold_req;
	bit          no_idle;

	orbit_phase_lock_speed dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int draw_gap();
		if (no_idle || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	function automatic int unsigned due_count();
		return due_wr - due_rd;
	endfunction

	function automatic void expect_result(input speed_cmd_t c);
		due_buf[due_wr % DUE_DEPTH] = c;
		due_wr++;
	endfunction

	function automatic speed_cmd_t take_expected();
		speed_cmd_t c;
		c = due_buf[due_rd % DUE_DEPTH];
		due_rd++;
		return c;
	endfunction

	// angle of (dx, dy) in 1/65536 turns, vectoring CORDIC with floor shifts
	function automatic logic [15:0] bearing_of(input longint dx_in, input longint dy_in);
		longint      dx, dy, xs, ys;
		logic [31:0] acc;
		logic [31:0] rounded;
		dx = dx_in;
		dy = dy_in;
		acc = 32'd0;
		if (dx == 0 && dy == 0)
			return 16'd0;
		if (dx < 0) begin
			dx = -dx;
			dy = -dy;
			acc = 32'h8000_0000;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = dx >>> i;
			ys = dy >>> i;
			if (dy >= 0) begin
				dx = dx + ys;
				dy = dy - xs;
				acc = acc + ATAN_TAB[i];
			end else begin
				dx = dx - ys;
				dy = dy + xs;
				acc = acc - ATAN_TAB[i];
			end
		end
		rounded = acc + 32'h0000_8000;
		return rounded[31:16];
	endfunction

	function automatic bit predict_speed(input step_row_t row, output speed_cmd_t cmd);
		logic [31:0]        elapsed;
		logic [63:0]        sweep;
		logic [15:0]        actual, target, errw;
		logic signed [15:0] err;
		longint             spd, diff;
		cmd = '0;
		if (row.req == REQ_STOP) begin
			lock_running = 1'b0;
			return 1'b0;
		end
		if (int'(row.veh) >= VEHICLES)
			return 1'b0;
		if (!lock_running) begin
			lock_running = 1'b1;
			lock_t0 = row.now;
		end
		elapsed = row.now - lock_t0;
		actual = bearing_of(longint'($signed(row.px)) - longint'(ring_x),
		                    longint'($signed(row.py)) - longint'(ring_y));
		sweep = {32'd0, sweep_rate} * {32'd0, elapsed};
		target = slot_reg[16*row.veh +: 16] + sweep[31:16];
		errw = target - actual;
		err = $signed(errw);
		spd = longint'(base_spd) + ((longint'(gain) * longint'(err) + 32768) >>> 16);
		if (spd > longint'(ceil_spd))
			spd = longint'(ceil_spd);
		if (spd < longint'(floor_spd))
			spd = longint'(floor_spd);
		diff = spd - longint'(sent_speed[row.veh]);
		if (diff < 0)
			diff = -diff;
		if (sent_ok[row.veh] && diff <= SEND_MARGIN)
			return 1'b0;
		sent_speed[row.veh] = spd[15:0];
		sent_ok[row.veh] = 1'b1;
		cmd.veh = row.veh;
		cmd.err = errw;
		cmd.speed = spd[15:0];
		return 1'b1;
	endfunction

	function automatic step_row_t make_row(input row_check_t kind, input req_kind_t req,
	                                       input logic [1:0] veh, input logic [31:0] px,
	                                       input logic [31:0] py, input logic [31:0] now,
	                                       input logic [15:0] exp_err,
	                                       input logic [15:0] exp_speed);
		step_row_t r;
		r.kind = kind;
		r.req = req;
		r.veh = veh;
		r.px = px;
		r.py = py;
		r.now = now;
		r.exp_err = exp_err;
		r.exp_speed = exp_speed;
		return r;
	endfunction

	// directed items at the reset settings: centre 0, sweep 0, base 2048
	function automatic step_row_t directed_row(input int idx);
		step_row_t r;
		r = '0;
		case (idx)
			// each vehicle at the centre: zero error, base speed, first send
			0:  r = make_row(ROW_EXPECT_ONE, REQ_UPDATE, 2'd0, 32'd0, 32'd0, 32'd1000,
			                 16'd0, 16'd2048);
			1:  r = make_row(ROW_EXPECT_ONE, REQ_UPDATE, 2'd1, 32'd0, 32'd0, 32'd1010,
			                 16'd0, 16'd2048);
			2:  r = make_row(ROW_EXPECT_ONE, REQ_UPDATE, 2'd2, 32'd0, 32'd0, 32'd1020,
			                 16'd0, 16'd2048);
			3:  r = make_row(ROW_EXPECT_ONE, REQ_UPDATE, 2'd3, 32'd0, 32'd0, 32'd1030,
			                 16'd0, 16'd2048);
			// same speed again: suppressed
			4:  r = make_row(ROW_EXPECT_NONE, REQ_UPDATE, 2'd0, 32'd0, 32'd0, 32'd1040,
			                 16'd0, 16'd0);
			// due west: half a turn of error
			5:  r = make_row(ROW_PREDICT, REQ_UPDATE, 2'd0, -32'sd1000, 32'd0, 32'd1050,
			                 16'd0, 16'd0);
			6:  r = make_row(ROW_PREDICT, REQ_UPDATE, 2'd1, 32'd0, 32'd1000, 32'd1060,
			                 16'd0, 16'd0);
			7:  r = make_row(ROW_PREDICT, REQ_UPDATE, 2'd2, 32'h7FFF_FFFF, 32'h8000_0000,
			                 32'd1070, 16'd0, 16'd0);
			8:  r = make_row(ROW_PREDICT, REQ_UPDATE, 2'd3, 32'h8000_0000, 32'h7FFF_FFFF,
			                 32'd1080, 16'd0, 16'd0);
			9:  r = make_row(ROW_EXPECT_NONE, REQ_STOP, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			                 32'hFFFF_FFFF, 16'd0, 16'd0);
			// clock restarts near the top of the time range
			10: r = make_row(ROW_PREDICT, REQ_UPDATE, 2'd0, 32'd0, 32'd0, 32'hFFFF_FFF0,
			                 16'd0, 16'd0);
			11: r = make_row(ROW_EXPECT_NONE, REQ_UPDATE, 2'd0, 32'd0, 32'd0, 32'h0000_000F,
			                 16'd0, 16'd0);
			12: r = make_row(ROW_PREDICT, REQ_UPDATE, 2'd1, 32'd1, -32'sd1, 32'd20,
			                 16'd0, 16'd0);
			13: r = make_row(ROW_PREDICT, REQ_UPDATE, 2'd2, -32'sd1, 32'd0, 32'd30,
			                 16'd0, 16'd0);
			14: r = make_row(ROW_PREDICT, REQ_UPDATE, 2'd3, -32'sd1, -32'sd1, 32'd40,
			                 16'd0, 16'd0);
			15: r = make_row(ROW_EXPECT_NONE, REQ_STOP, 2'd0, 32'd0, 32'd0, 32'd0,
			                 16'd0, 16'd0);
			16: r = make_row(ROW_PREDICT, REQ_UPDATE, 2'd0, 32'd0, -32'sd5000, 32'd500,
			                 16'd0, 16'd0);
			default: r = '0;
		endcase
		return r;
	endfunction

	// enter at a falling edge, leave at a falling edge with tvalid still up
	task automatic send_item(input step_row_t row);
		int         gap;
		speed_cmd_t cmd;
		speed_cmd_t typed;
		bit         sends;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {6'd0, row.now, row.py, row.px, row.veh};
		s_tuser = row.req;
		do @(posedge clk); while (s_tready !== 1'b1);
		sends = predict_speed(row, cmd);
		case (row.kind)
			ROW_PREDICT: begin
				if (sends)
					expect_result(cmd);
			end
			ROW_EXPECT_ONE: begin
				typed.veh = row.veh;
				typed.err = row.exp_err;
				typed.speed = row.exp_speed;
				expect_result(typed);
			end
			default: ;
		endcase
		items_sent++;
		if (row.req == REQ_STOP)
			stops_sent++;
		@(negedge clk);
	endtask

	// drop tvalid, wait for every result, then let the datapath go quiet
	task automatic drain();
		s_tvalid = 1'b0;
		while (due_count() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		case (idx)
			REG_CENTER_X:      ring_x = val[31:0];
			REG_CENTER_Y:      ring_y = val[31:0];
			REG_ANGLE_RATE:    sweep_rate = val[31:0];
			REG_BASE_SPEED:    base_spd = val[15:0];
			REG_ERROR_GAIN:    gain = val[15:0];
			REG_SPEED_FLOOR:   floor_spd = val[15:0];
			REG_SPEED_CEILING: ceil_spd = val[15:0];
			REG_SLOT_PHASES:   slot_reg = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_setting(input int p);
		logic [31:0] cx, cy, rate;
		logic [15:0] bs, eg, fl, ce;
		logic [63:0] slots;
		cx = $urandom;
		cy = $urandom;
		rate = $urandom;
		bs = $urandom_range(0, 65535);
		eg = $urandom_range(0, 65535);
		fl = $urandom_range(0, 2047);
		ce = $urandom_range(2048, 65535);
		slots = {$urandom, $urandom};
		case (p)
			0: begin
				cx = $signed(cx) >>> 8;
				cy = $signed(cy) >>> 8;
				rate = $urandom_range(0, 32'h0010_0000);
				bs = BASE_SPEED_RST;
				eg = ERROR_GAIN_RST;
				fl = SPEED_FLOOR_RST;
				ce = SPEED_CEILING_RST;
			end
			1: begin
				cx = 32'h7FFF_FFFF;
				cy = 32'h8000_0000;
				rate = 32'hFFFF_FFFF;
				bs = 16'hFFFF;
				eg = 16'hFFFF;
				fl = 16'h0000;
				ce = 16'hFFFF;
				slots = '1;
			end
			2: begin
				cx = '0;
				cy = '0;
				rate = '0;
				bs = '0;
				eg = '0;
				fl = '0;
				ce = '0;
				slots = '0;
			end
			// floor above ceiling: floor wins
			3: begin
				fl = 16'd3000;
				ce = 16'd1000;
				rate = $urandom_range(0, 32'h0010_0000);
			end
			7: begin
				cx = 32'h8000_0000;
				cy = 32'h7FFF_FFFF;
				rate = 32'd1;
				bs = 16'd0;
				eg = 16'hFFFF;
				fl = 16'd0;
				ce = 16'hFFFF;
			end
			default: ;
		endcase
		write_reg(REG_CENTER_X, {32'd0, cx});
		write_reg(REG_CENTER_Y, {32'd0, cy});
		write_reg(REG_ANGLE_RATE, {32'd0, rate});
		write_reg(REG_BASE_SPEED, {48'd0, bs});
		write_reg(REG_ERROR_GAIN, {48'd0, eg});
		write_reg(REG_SPEED_FLOOR, {48'd0, fl});
		write_reg(REG_SPEED_CEILING, {48'd0, ce});
		write_reg(REG_SLOT_PHASES, slots);
		cfg_we = 1'b0;
		settings_used++;
	endtask

	// mostly updates around the ring centre with time moving forward
	function automatic step_row_t random_row();
		step_row_t r;
		int        ox, oy;
		int        sel;
		r = make_row(ROW_PREDICT, REQ_UPDATE, 2'($urandom_range(0, 3)), $urandom, $urandom,
		             $urandom, 16'd0, 16'd0);
		sel = $urandom_range(0, 99);
		if (sel < 5) begin
			r.req = REQ_STOP;
			return r;
		end
		if (sel < 8)
			now_t = $urandom;
		else
			now_t = now_t + $urandom_range(1, 300);
		r.now = now_t;
		case ($urandom_range(0, 9))
			0: ;
			1: begin
				r.px = ring_x;
				r.py = ring_y;
			end
			2: begin
				r.px = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				r.py = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			end
			default: begin
				ox = int'($urandom) >>> $urandom_range(1, 31);
				oy = int'($urandom) >>> $urandom_range(1, 31);
				r.px = ring_x + ox;
				r.py = ring_y + oy;
			end
		endcase
		return r;
	endfunction

	// result side: per-item stall, plus one long hold on request
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			stall = draw_gap();
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		speed_cmd_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			results_seen++;
			if (due_count() == 0) begin
				fail_count++;
				$display("%0t: unexpected result veh=%0d err=%0d speed=%0d", $time,
				         m_tdata[1:0], $signed(m_tdata[17:2]), m_tdata[33:18]);
			end else begin
				want = take_expected();
				if (m_tdata[1:0] !== want.veh || m_tdata[17:2] !== want.err
				    || m_tdata[33:18] !== want.speed) begin
					fail_count++;
					$display("%0t: expected veh=%0d err=%0d speed=%0d, got veh=%0d err=%0d speed=%0d",
					         $time, want.veh, $signed(want.err), want.speed,
					         m_tdata[1:0], $signed(m_tdata[17:2]), m_tdata[33:18]);
				end
			end
		end
	end

	// watchdog: cycles in which no item moves on any port
	always @(posedge clk) begin
		if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout, %0d results still pending", $time, due_count());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		step_row_t row;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		hold_req = 1'b0;
		no_idle = 1'b0;
		fail_count = 0;
		items_sent = 0;
		stops_sent = 0;
		results_seen = 0;
		settings_used = 0;
		quiet_cycles = 0;
		due_wr = 0;
		due_rd = 0;
		now_t = 32'd2000;
		ring_x = '0;
		ring_y = '0;
		sweep_rate = '0;
		base_spd = BASE_SPEED_RST;
		gain = ERROR_GAIN_RST;
		floor_spd = SPEED_FLOOR_RST;
		ceil_spd = SPEED_CEILING_RST;
		slot_reg = '0;
		lock_running = 1'b0;
		lock_t0 = '0;
		for (int v = 0; v < 4; v++) begin
			sent_speed[v] = '0;
			sent_ok[v] = 1'b0;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_item(directed_row(i));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			apply_setting(p);
			no_idle = (p == 5);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// long receiver hold while updates keep coming back to back
				if (p == 3 && n == 10) begin
					hold_req = 1'b1;
					no_idle = 1'b1;
				end
				if (p == 3 && n == 40)
					no_idle = 1'b0;
				if (p == 6 && n == 50)
					drain();
				row = random_row();
				send_item(row);
			end
			drain();
		end
		no_idle = 1'b0;

		$display("Covered %0d items (%0d stop requests) over %0d register settings.",
		         items_sent, stops_sent, settings_used + 1);
		$display("Checked %0d speed commands, %0d mismatches.", results_seen, fail_count);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
sv/opls_pkg.sv
sv/opls_ctrl.sv
sv/opls_dp.sv
sv/orbit_phase_lock_speed.sv
bench/tb_top.sv
